### hdl/integer_square_root_core_defines.svh
// Assertion macros for the integer square root core.
// Included by the top level; needs nothing else.
`ifndef INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define ISR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isr assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define ISR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isr assertion failed");

`endif

### hdl/isr_pkg.sv
// Shared constants and types of the integer square root core.
// Used by isr_ctrl, isr_dp and the top level; depends on nothing.
package isr_pkg;

  // Default radicand width used by the search
  localparam int DATA_WIDTH_DEF = 32;

  // Port field widths
  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new radicand and clear the root
    logic step;     // decide one root bit
    logic publish;  // copy the finished root to the output register
  } isr_cmd_t;

endpackage

### hdl/isr_dp.sv
// Datapath of the integer square root core: radicand shifter, partial
// remainder, root register and output word. Depends on isr_pkg.
module isr_dp #(
  parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  isr_pkg::isr_cmd_t            cmd,
  input  logic [isr_pkg::RADICAND_W-1:0] radicand,
  output logic [isr_pkg::ROOT_W-1:0]     root
);

  localparam int RB = (DATA_WIDTH + 1) / 2;   // root bits
  localparam int XW = 2 * RB;                 // radicand bits, padded to even
  localparam int KW = (DATA_WIDTH < isr_pkg::RADICAND_W) ? DATA_WIDTH
                                                           : isr_pkg::RADICAND_W;

  logic [XW-1:0]               x_r;
  logic [XW-1:0]               x_nxt;
  logic [RB:0]                 rem_r;
  logic [RB:0]                 rem_nxt;
  logic [RB-1:0]               root_r;
  logic [RB-1:0]               root_nxt;
  logic [isr_pkg::ROOT_W-1:0]  out_r;
  logic [RB+1:0]               rem_sh;
  logic [RB+1:0]               trial;
  logic [RB+2:0]               diff;
  logic                        fits;

  // Bring down the next radicand digit pair and test the trial divisor
  always_comb begin
    rem_sh = {rem_r[RB-1:0], x_r[XW-1 -: 2]};
    trial  = {root_r, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = !diff[RB+2];
  end

  // Next values of the iteration registers
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (cmd.load) begin
      x_nxt    = XW'(radicand[KW-1:0]);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cmd.step) begin
      x_nxt    = x_r << 2;
      rem_nxt  = fits ? diff[RB:0] : rem_sh[RB:0];
      root_nxt = (root_r << 1) | RB'(fits);
    end
  end

  // Hold iteration state and the output word
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (cmd.publish) begin
      out_r <= isr_pkg::ROOT_W'(root_r);
    end
  end

  assign root = out_r;

endmodule

### hdl/isr_ctrl.sv
// Controller of the integer square root core: input handshake, step
// counter and output valid. Depends on isr_pkg.
module isr_ctrl #(
  parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output isr_pkg::isr_cmd_t cmd
);

  localparam int RB = (DATA_WIDTH + 1) / 2;
  localparam int CW = (RB > 1) ? $clog2(RB) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CW'(RB - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, step count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/integer_square_root_core.sv
// Integer square root core, top level.
// Accepts one 32-bit unsigned radicand word on the in_ channel and returns
// one 16-bit word, the floor of its square root, on the out_ channel.
// Both channels use valid/stall: a word moves on a rising edge with valid
// high and stall low.
// The root is found one bit per cycle, most significant first, by a shared
// compare-and-subtract on a partial remainder; the (DATA_WIDTH+1)/2 root
// bits set the run length.
// The result turns valid after the load, the root steps and the publish
// into the output register. One word is taken at a time; the next can be
// accepted in the cycle after the result is loaded.
// A finished result waits in the output register while out_stall is high;
// the core still accepts and computes the next word meanwhile, and holds
// that one in its finish state until the output register frees.
// Radicand bits at and above DATA_WIDTH are ignored.
// Reset (rst_n low, synchronous) drops any word in flight and clears
// out_valid; in_stall is low right after reset.
// Depends on isr_pkg, isr_ctrl, isr_dp and the assertion macro header.
`include "integer_square_root_core_defines.svh"

module integer_square_root_core #(
  parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [isr_pkg::RADICAND_W-1:0] in_radicand,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [isr_pkg::ROOT_W-1:0]     out_root
);

  isr_pkg::isr_cmd_t cmd;

  // Sequence the search
  isr_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Run the digit-by-digit root recurrence
  isr_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .radicand (in_radicand),
    .root     (out_root)
  );

  // Only one datapath command at a time
  `ISR_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.publish}))
  // A result never overwrites one that is still waiting
  `ISR_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.publish, !out_valid || !out_stall)
  // The core is busy right after taking a word
  `ISR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

### tb/root_scoreboard_pkg.sv
// Scoreboard for the integer square root core testbench: predicts each root
// word and checks the returned words in order. Depends on isr_pkg.
package root_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  class root_scoreboard;
    logic [isr_pkg::ROOT_W-1:0] expected_roots[$];
    int                         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Floor square root, one root bit per step, squares kept at 64 bits
    static function logic [isr_pkg::ROOT_W-1:0] floor_sqrt(
      logic [isr_pkg::RADICAND_W-1:0] radicand
    );
      localparam int WIDTH     = isr_pkg::DATA_WIDTH_DEF;
      localparam int ROOT_BITS = (WIDTH + 1) / 2;
      logic [63:0] masked;
      logic [31:0] guess;
      logic [31:0] trial;
      masked = {32'b0, radicand};
      if (WIDTH < 64) begin
        masked = masked & ((64'd1 << WIDTH) - 64'd1);
      end
      guess = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
        trial = guess | (32'd1 << b);
        if ({32'b0, trial} * {32'b0, trial} <= masked) begin
          guess = trial;
        end
      end
      return guess[isr_pkg::ROOT_W-1:0];
    endfunction

    // Note an accepted radicand word and queue its root
    function void note_radicand(logic [isr_pkg::RADICAND_W-1:0] radicand);
      expected_roots.push_back(floor_sqrt(radicand));
    endfunction

    // Compare a returned root word with the oldest queued root
    function void check_root(logic [isr_pkg::ROOT_W-1:0] root);
      logic [isr_pkg::ROOT_W-1:0] want;
      if (expected_roots.size() == 0) begin
        $error("out_root: no root expected, actual %0d", root);
        mismatches++;
      end else begin
        want = expected_roots.pop_front();
        if (root !== want) begin
          $error("out_root mismatch: expected %0d actual %0d", want, root);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

endpackage

### tb/integer_square_root_core_tb.sv
// Top-level testbench for integer_square_root_core: directed and random
// radicand words with random idling on both channels.
// Depends on isr_pkg, root_scoreboard_pkg and the core itself.
module integer_square_root_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1200;
  localparam int IDLE_PCT     = 37;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [isr_pkg::RADICAND_W-1:0] in_radicand;
  logic                           out_valid;
  logic                           out_stall;
  logic [isr_pkg::ROOT_W-1:0]     out_root;

  logic                                quiet_stretch;
  root_scoreboard_pkg::root_scoreboard roots;

  integer_square_root_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_radicand(in_radicand),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_root   (out_root)
  );

  // Free-running 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Check each returned word, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      roots.check_root(out_root);
    end
    out_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Offer one radicand word after random idle cycles; hold it until taken
  task automatic send_radicand(input logic [isr_pkg::RADICAND_W-1:0] value);
    while (!quiet_stretch && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_radicand <= value;
    do @(posedge clk); while (in_stall);
    roots.note_radicand(value);
  endtask

  // Drop valid and wait until every queued root has come back
  task automatic drain_roots();
    in_valid <= 1'b0;
    do @(posedge clk); while (roots.pending() != 0);
  endtask

  // Random radicand with a bias toward squares, their neighbors and small values
  function automatic logic [isr_pkg::RADICAND_W-1:0] pick_radicand();
    logic [31:0] k;
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: begin
        k = $urandom_range(0, 65535);
        v = k * k;
      end
      3: begin
        k = $urandom_range(1, 65535);
        v = k * k - 1;
      end
      4: v = $urandom_range(0, 1023);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  initial begin
    logic [isr_pkg::RADICAND_W-1:0] directed[$];
    roots         = new();
    quiet_stretch = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_radicand  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, tiny values, exact squares and their neighbors, field extremes
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
                 32'd255, 32'd256, 32'hFFFF, 32'h1_0000, 32'h3FFF_FFFF,
                 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFE_0002,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (directed[i]) begin
      send_radicand(directed[i]);
    end
    drain_roots();

    // Random words, with one stretch where neither side idles
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_stretch = (n >= 500 && n < 700);
      if (n == 850) begin
        drain_roots();
      end
      send_radicand(pick_radicand());
    end
    quiet_stretch = 1'b0;
    drain_roots();

    // Let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (roots.mismatches == 0 && roots.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/isr_pkg.sv
hdl/isr_dp.sv
hdl/isr_ctrl.sv
hdl/integer_square_root_core.sv
tb/root_scoreboard_pkg.sv
tb/integer_square_root_core_tb.sv
